// ----- rtl/pmd_pkg.sv -----
// Shared types and constants of the pedal misapplication detector.
package pmd_pkg;

   localparam int WINDOW_DEPTH_DEF = 16;

   localparam int PRESS_W    = 12;
   localparam int DUTY_W     = 8;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [PRESS_W-1:0] PRESS_LIMIT_RST = 12'd4095;
   localparam logic [DUTY_W-1:0]  IDLE_DUTY_RST   = 8'd127;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_DUTY   = 1'd1;

   // request opcodes
   localparam logic OP_RECORD   = 1'b0;
   localparam logic OP_EVALUATE = 1'b1;

   // drive mode that, with a red light, counts under autohold
   localparam logic [MODE_W-1:0] MODE_HOLD = 3'd1;

   typedef struct packed {
      logic push;        // write one sample at the head
      logic scan_start;  // walk the window from the oldest entry
   } ring_cmd_type;

   typedef struct packed {
      logic rd_valid;    // read data is a window entry
      logic busy;        // scan still issuing or data in flight
   } ring_stat_type;

endpackage

// ----- rtl/pmd_if.sv -----
// Request and response channel interfaces of the pedal misapplication detector.
interface pmd_req_if
   import pmd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [DUTY_W-1:0]  duty_sample;
   logic [PRESS_W-1:0] accel_press;
   logic [PRESS_W-1:0] brake_press;
   logic               red_light;
   logic               autohold_on;
   logic [MODE_W-1:0]  drive_mode;
   logic               danger;

   modport source (
      output valid, opcode, duty_sample, accel_press, brake_press,
             red_light, autohold_on, drive_mode, danger,
      input  ready
   );
   modport sink (
      input  valid, opcode, duty_sample, accel_press, brake_press,
             red_light, autohold_on, drive_mode, danger,
      output ready
   );
endinterface

interface pmd_rsp_if;
   logic valid;
   logic ready;
   logic start_abnormal;
   logic finish_abnormal;

   modport source (output valid, start_abnormal, finish_abnormal, input ready);
   modport sink   (input valid, start_abnormal, finish_abnormal, output ready);
endinterface

// ----- rtl/pedal_misapplication_detector_unit.sv -----
// Pedal misapplication detector: top level with sequencer and result register.
//
// The block keeps a ring of the last WINDOW_DEPTH-1 motor duty samples and
// judges pedal requests against it. A record request writes one sample and
// gives no response. An evaluate request gives one response with
// start_abnormal and finish_abnormal, loaded into the response register
// after the window walk ends; an empty window reads no entries. The window
// is walked one entry per cycle through the single read port of the sample
// memory and one shared compare unit.
// req ready is low while an evaluation runs; a finished response waits in its
// own register, so a new request may be taken while it is still unclaimed.
// Under autohold the window test looks for a zero duty, otherwise for a duty
// at or below idle_duty; an empty window never matches. Registers are written
// through csr_wr_en/csr_index/csr_data (0: press_limit, 1: idle_duty) and
// must only be written while no evaluation is in progress.
module pedal_misapplication_detector_unit
   import pmd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pmd_req_if.sink               req_chan,
   pmd_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [PRESS_W-1:0] press_limit_ff;
   logic [DUTY_W-1:0]  idle_duty_ff;

   // latched per evaluation
   logic               pre_ff, pre_in;       // non-window part of start flag
   logic               finish_ff, finish_in;
   logic [DUTY_W-1:0]  limit_ff, limit_in;   // 0 under autohold: v <= 0 is v == 0
   logic               match_ff, match_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_start_ff, rsp_finish_ff;

   logic               req_fire;
   logic               load_rsp;
   logic               hold_cond;
   ring_cmd_type       ring_cmd;
   ring_stat_type      ring_stat;
   logic [DUTY_W-1:0]  ring_data;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_rsp       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign hold_cond = req_chan.danger ||
                      ((req_chan.drive_mode == MODE_HOLD) && req_chan.red_light);

   assign ring_cmd.push       = req_fire && (req_chan.opcode == OP_RECORD);
   assign ring_cmd.scan_start = req_fire && (req_chan.opcode == OP_EVALUATE);

   pmd_duty_ring #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ring_cmd),
      .push_data (req_chan.duty_sample),
      .stat      (ring_stat),
      .rd_data   (ring_data)
   );

   always_comb begin
      state_in  = state_ff;
      pre_in    = pre_ff;
      finish_in = finish_ff;
      limit_in  = limit_ff;
      match_in  = match_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ring_cmd.scan_start) begin
               if (req_chan.autohold_on) begin
                  pre_in   = hold_cond && (req_chan.accel_press != '0);
                  limit_in = '0;
               end else begin
                  pre_in   = req_chan.danger && (req_chan.accel_press >= press_limit_ff);
                  limit_in = idle_duty_ff;
               end
               finish_in = (req_chan.brake_press >= press_limit_ff);
               match_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // shared compare on each entry as it leaves the memory
            if (ring_stat.rd_valid && (ring_data <= limit_ff)) begin
               match_in = 1'b1;
            end
            if (!ring_stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         press_limit_ff <= PRESS_LIMIT_RST;
         idle_duty_ff   <= IDLE_DUTY_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_PRESS_LIMIT: press_limit_ff <= csr_data[PRESS_W-1:0];
               REG_IDLE_DUTY:   idle_duty_ff   <= csr_data[DUTY_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_ff    <= pre_in;
      finish_ff <= finish_in;
      limit_ff  <= limit_in;
      match_ff  <= match_in;
      if (load_rsp) begin
         rsp_start_ff  <= pre_ff && match_ff;
         rsp_finish_ff <= finish_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.start_abnormal  = rsp_start_ff;
   assign rsp_chan.finish_abnormal = rsp_finish_ff;

endmodule

// ----- rtl/pmd_duty_ring.sv -----
// Duty history ring: sample memory, head and tail pointers, window scan port.
module pmd_duty_ring
   import pmd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_cmd_type      cmd,
   input  logic [DUTY_W-1:0] push_data,
   output ring_stat_type     stat,
   output logic [DUTY_W-1:0] rd_data
);

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      wrap_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   logic [DUTY_W-1:0] mem [WINDOW_DEPTH];

   logic [IDX_W-1:0]  oldest_ff, oldest_in;
   logic [IDX_W-1:0]  next_ff, next_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              scanning_ff, scanning_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [DUTY_W-1:0] rd_data_ff;
   logic              issue;
   logic [IDX_W-1:0]  next_inc;

   assign next_inc = wrap_inc(next_ff);
   assign issue    = scanning_ff && (scan_ff != next_ff);

   always_comb begin
      oldest_in   = oldest_ff;
      next_in     = next_ff;
      scan_in     = scan_ff;
      scanning_in = scanning_ff;
      rd_valid_in = issue;
      if (cmd.push) begin
         next_in = next_inc;
         // full: drop the oldest sample
         if (next_inc == oldest_ff) begin
            oldest_in = wrap_inc(oldest_ff);
         end
      end
      if (cmd.scan_start) begin
         scan_in     = oldest_ff;
         scanning_in = (oldest_ff != next_ff);
      end else if (scanning_ff) begin
         if (issue) begin
            scan_in     = wrap_inc(scan_ff);
            scanning_in = (wrap_inc(scan_ff) != next_ff);
         end else begin
            scanning_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff   <= '0;
         next_ff     <= '0;
         scan_ff     <= '0;
         scanning_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         oldest_ff   <= oldest_in;
         next_ff     <= next_in;
         scan_ff     <= scan_in;
         scanning_ff <= scanning_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[next_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[scan_ff];
      end
   end

   assign stat.rd_valid = rd_valid_ff;
   assign stat.busy     = scanning_ff | rd_valid_ff;
   assign rd_data       = rd_data_ff;

endmodule

// ----- rtl/pmd_checker.sv -----
// Port-level assertions of the pedal misapplication detector, bound to the top level.
module pmd_checker
   import pmd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_opcode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_start_abnormal,
   input logic rsp_finish_abnormal
);

   // a response waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   // a waiting response keeps its flags
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_start_abnormal) && $stable(rsp_finish_abnormal))
      else $error("waiting response changed");

   // an evaluation occupies the block
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_EVALUATE) |=> !req_ready)
      else $error("request taken during evaluation");

   // a record request raises no response
   a_record_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_RECORD) |=> !$rose(rsp_valid))
      else $error("response after record request");

   // nothing pending straight after reset
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pedal_misapplication_detector_unit pmd_checker u_pmd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_opcode          (req_chan.opcode),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_start_abnormal  (rsp_chan.start_abnormal),
   .rsp_finish_abnormal (rsp_chan.finish_abnormal)
);
